[rtl/visual_ring_alignment_servo_assert.svh]
// Assertion macros used by the checker file of the alignment servo.
`ifndef VISUAL_RING_ALIGNMENT_SERVO_ASSERT_SVH
`define VISUAL_RING_ALIGNMENT_SERVO_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VRAS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("alignment servo check failed");

// The consequent must hold in the cycle after the antecedent.
`define VRAS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("alignment servo check failed");

`endif

[rtl/vras_pkg.sv]
package vras_pkg;

    // Event codes carried in s_tuser.
    localparam logic [1:0] ACT_START_RING  = 2'd0;
    localparam logic [1:0] ACT_START_OTHER = 2'd1;
    localparam logic [1:0] ACT_CANCEL      = 2'd2;
    localparam logic [1:0] ACT_UPDATE      = 2'd3;

    // Run status codes.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OK   = 2'd2;
    localparam logic [1:0] ST_FAIL = 2'd3;

    // Chassis state codes; any code from fault upward counts as a fault.
    localparam logic [1:0] CH_READY = 2'd0;
    localparam logic [1:0] CH_BUSY  = 2'd1;
    localparam logic [1:0] CH_FAULT = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_TARGET_DX        = 3'd0;
    localparam logic [2:0] REG_TARGET_DY        = 3'd1;
    localparam logic [2:0] REG_CENTER_TOLERANCE = 3'd2;
    localparam logic [2:0] REG_FINE_ZONE        = 3'd3;
    localparam logic [2:0] REG_MIN_QUALITY      = 3'd4;
    localparam logic [2:0] REG_REQUIRED_STABLE  = 3'd5;
    localparam logic [2:0] REG_FORWARD_GAIN     = 3'd6;
    localparam logic [2:0] REG_RIGHT_GAIN       = 3'd7;

    localparam int ADDR_W   = 5;
    localparam int ITEM_W   = 82;
    localparam int IN_TDATA_W  = 88;
    localparam int RESULT_W = 39;
    localparam int OUT_TDATA_W = 40;
    localparam int LIMIT_W  = 15;

    // Configuration register contents.
    typedef struct packed {
        logic [11:0] target_dx;
        logic [11:0] target_dy;
        logic [10:0] center_tolerance;
        logic [10:0] fine_zone;
        logic [7:0]  min_quality;
        logic [7:0]  required_stable;
        logic [15:0] forward_gain;
        logic [15:0] right_gain;
    } cfg_t;

    // Input item payload, first field in the highest bits.
    typedef struct packed {
        logic [11:0] det_dy;
        logic [11:0] det_dx;
        logic [7:0]  det_quality;
        logic        det_found;
        logic [7:0]  det_target;
        logic [3:0]  det_mode;
        logic        det_valid;
        logic        ack_failed;
        logic        move_refused;
        logic [1:0]  chassis_state;
        logic [31:0] now_ms;
    } item_t;

    // Result item payload, first field in the highest bits.
    typedef struct packed {
        logic        camera_set_target;
        logic        camera_reset;
        logic        stop_chassis;
        logic [15:0] right_move;
        logic [15:0] forward_move;
        logic        move_valid;
        logic        start_accepted;
        logic [1:0]  status;
    } result_t;

endpackage

[rtl/vras_scale.sv]
// Scales a pixel error by a Q8 gain, rounds to nearest with ties away from
// zero, and clamps the magnitude to the given limit.
module vras_scale (
    input  logic [12:0]                 err,
    input  logic [15:0]                 gain,
    input  logic [vras_pkg::LIMIT_W-1:0] limit,
    output logic [15:0]                 move
);

    logic signed [28:0] product;
    logic        [27:0] mag;
    logic        [19:0] rounded;
    logic        [14:0] clamped;
    logic        [27:0] biased;

    // Signed product, at most 28 bits of magnitude.
    assign product = $signed(err) * $signed(gain);

    // Magnitude, rounding and clamping.
    always_comb
    begin
        if (product[28])
        begin
            mag = 28'(-product);
        end
        else
        begin
            mag = product[27:0];
        end
        biased  = mag + 28'd128;
        rounded = biased[27:8];
        if (rounded > {5'd0, limit})
        begin
            clamped = limit;
        end
        else
        begin
            clamped = rounded[14:0];
        end
        if (product[28])
        begin
            move = 16'(-{1'b0, clamped});
        end
        else
        begin
            move = {1'b0, clamped};
        end
    end

endmodule

[rtl/vras_cfg_regs.sv]
// Configuration registers behind an APB-style port.
module vras_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vras_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output vras_pkg::cfg_t                cfg
);

    vras_pkg::cfg_t cfg_reg;
    vras_pkg::cfg_t cfg_next;
    logic [2:0]     index;
    logic           wr_en;

    assign pready = 1'b1;
    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                vras_pkg::REG_TARGET_DX:        cfg_next.target_dx        = pwdata[11:0];
                vras_pkg::REG_TARGET_DY:        cfg_next.target_dy        = pwdata[11:0];
                vras_pkg::REG_CENTER_TOLERANCE: cfg_next.center_tolerance = pwdata[10:0];
                vras_pkg::REG_FINE_ZONE:        cfg_next.fine_zone        = pwdata[10:0];
                vras_pkg::REG_MIN_QUALITY:      cfg_next.min_quality      = pwdata[7:0];
                vras_pkg::REG_REQUIRED_STABLE:  cfg_next.required_stable  = pwdata[7:0];
                vras_pkg::REG_FORWARD_GAIN:     cfg_next.forward_gain     = pwdata[15:0];
                vras_pkg::REG_RIGHT_GAIN:       cfg_next.right_gain       = pwdata[15:0];
            endcase
        end
    end

    // Read mux, zero-extended to the bus width.
    always_comb
    begin
        unique case (index)
            vras_pkg::REG_TARGET_DX:        prdata = 32'(cfg_reg.target_dx);
            vras_pkg::REG_TARGET_DY:        prdata = 32'(cfg_reg.target_dy);
            vras_pkg::REG_CENTER_TOLERANCE: prdata = 32'(cfg_reg.center_tolerance);
            vras_pkg::REG_FINE_ZONE:        prdata = 32'(cfg_reg.fine_zone);
            vras_pkg::REG_MIN_QUALITY:      prdata = 32'(cfg_reg.min_quality);
            vras_pkg::REG_REQUIRED_STABLE:  prdata = 32'(cfg_reg.required_stable);
            vras_pkg::REG_FORWARD_GAIN:     prdata = 32'(cfg_reg.forward_gain);
            vras_pkg::REG_RIGHT_GAIN:       prdata = 32'(cfg_reg.right_gain);
        endcase
    end

    // Register bank with its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_dx        <= 12'd0;
            cfg_reg.target_dy        <= 12'd0;
            cfg_reg.center_tolerance <= 11'd4;
            cfg_reg.fine_zone        <= 11'd40;
            cfg_reg.min_quality      <= 8'd128;
            cfg_reg.required_stable  <= 8'd3;
            cfg_reg.forward_gain     <= 16'd256;
            cfg_reg.right_gain       <= 16'd256;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/vras_core.sv]
// Servo control: input register, status update and result register.
module vras_core #(
    parameter int TIMEOUT_MS   = 8000,
    parameter int STALE_MS     = 300,
    parameter int FINE_LIMIT   = 100,
    parameter int COARSE_LIMIT = 500,
    parameter int RING_ID      = 1,
    parameter int RING_MODE    = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_action,
    input  vras_pkg::item_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output vras_pkg::result_t out_result,
    input  vras_pkg::cfg_t    cfg
);

    // Handshake and pipeline registers.
    logic              in_valid_reg;
    logic [1:0]        action_reg;
    vras_pkg::item_t   item_reg;
    logic              out_valid_reg;
    vras_pkg::result_t result_reg;
    vras_pkg::result_t result_next;
    logic              advance;
    logic              take;

    // Servo state.
    logic [1:0]  run_status_reg, run_status_next;
    logic        move_pending_reg, move_pending_next;
    logic [7:0]  stable_count_reg, stable_count_next;
    logic [31:0] start_time_reg, start_time_next;
    logic [31:0] last_seen_reg, last_seen_next;

    // Decode of the registered item.
    logic        busy;
    logic        fault;
    logic        do_fail;
    logic [12:0] err_x;
    logic [12:0] err_y;
    logic [12:0] abs_x;
    logic [12:0] abs_y;
    logic        centered;
    logic        fine;
    logic [7:0]  count_inc;
    logic [vras_pkg::LIMIT_W-1:0] limit;
    logic [15:0] fwd_scaled;
    logic [15:0] rgt_scaled;
    logic [31:0] since_start;
    logic [31:0] since_seen;

    assign advance   = !out_valid_reg || out_ready;
    assign take      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_result = result_reg;

    assign busy  = (item_reg.chassis_state == vras_pkg::CH_BUSY);
    assign fault = (item_reg.chassis_state >= vras_pkg::CH_FAULT);

    // Pixel errors and their magnitudes.
    assign err_x = {item_reg.det_dx[11], item_reg.det_dx} - {cfg.target_dx[11], cfg.target_dx};
    assign err_y = {item_reg.det_dy[11], item_reg.det_dy} - {cfg.target_dy[11], cfg.target_dy};
    assign abs_x = err_x[12] ? 13'(-err_x) : err_x;
    assign abs_y = err_y[12] ? 13'(-err_y) : err_y;
    assign centered = (abs_x <= {2'd0, cfg.center_tolerance})
                   && (abs_y <= {2'd0, cfg.center_tolerance});
    assign fine = (abs_x <= {2'd0, cfg.fine_zone}) && (abs_y <= {2'd0, cfg.fine_zone});
    assign limit = fine ? vras_pkg::LIMIT_W'(FINE_LIMIT) : vras_pkg::LIMIT_W'(COARSE_LIMIT);
    assign count_inc = (stable_count_reg < cfg.required_stable)
                     ? stable_count_reg + 8'd1 : stable_count_reg;
    assign since_start = item_reg.now_ms - start_time_reg;
    assign since_seen  = item_reg.now_ms - last_seen_reg;

    // Move scaling on both axes.
    vras_scale u_scale_fwd (
        .err   (err_y),
        .gain  (cfg.forward_gain),
        .limit (limit),
        .move  (fwd_scaled)
    );

    vras_scale u_scale_rgt (
        .err   (err_x),
        .gain  (cfg.right_gain),
        .limit (limit),
        .move  (rgt_scaled)
    );

    // Event handling for the item in the input register.
    always_comb
    begin
        run_status_next   = run_status_reg;
        move_pending_next = move_pending_reg;
        stable_count_next = stable_count_reg;
        start_time_next   = start_time_reg;
        last_seen_next    = last_seen_reg;
        result_next       = '0;
        do_fail           = 1'b0;

        unique case (action_reg)
            vras_pkg::ACT_START_RING, vras_pkg::ACT_START_OTHER:
            begin
                if (run_status_reg != vras_pkg::ST_RUN)
                begin
                    if (action_reg == vras_pkg::ACT_START_OTHER)
                    begin
                        run_status_next            = vras_pkg::ST_OK;
                        result_next.start_accepted = 1'b1;
                    end
                    else if (!busy && !fault)
                    begin
                        move_pending_next             = 1'b0;
                        stable_count_next             = 8'd0;
                        start_time_next               = item_reg.now_ms;
                        last_seen_next                = 32'd0;
                        run_status_next               = vras_pkg::ST_RUN;
                        result_next.camera_set_target = 1'b1;
                        result_next.start_accepted    = 1'b1;
                    end
                end
            end
            vras_pkg::ACT_CANCEL:
            begin
                result_next.stop_chassis = (run_status_reg == vras_pkg::ST_RUN) && busy;
                result_next.camera_reset = 1'b1;
                move_pending_next        = 1'b0;
                run_status_next          = vras_pkg::ST_IDLE;
            end
            vras_pkg::ACT_UPDATE:
            begin
                if (run_status_reg == vras_pkg::ST_RUN)
                begin
                    priority if (item_reg.ack_failed || fault
                                 || (since_start >= 32'(TIMEOUT_MS)))
                    begin
                        do_fail = 1'b1;
                    end
                    else if (move_pending_reg)
                    begin
                        // Wait for the chassis to stop; the frame on that step is dropped.
                        if (!busy)
                        begin
                            move_pending_next = 1'b0;
                            last_seen_next    = 32'd0;
                        end
                    end
                    else if (!item_reg.det_valid)
                    begin
                        if ((last_seen_reg != 32'd0) && (since_seen > 32'(STALE_MS)))
                        begin
                            stable_count_next = 8'd0;
                        end
                    end
                    else if ((item_reg.det_mode == 4'(RING_MODE))
                             && (item_reg.det_target == 8'(RING_ID)))
                    begin
                        last_seen_next = item_reg.now_ms;
                        priority if (!item_reg.det_found
                                     || (item_reg.det_quality < cfg.min_quality))
                        begin
                            stable_count_next = 8'd0;
                        end
                        else if (centered)
                        begin
                            stable_count_next = count_inc;
                            if (count_inc >= cfg.required_stable)
                            begin
                                result_next.camera_reset = 1'b1;
                                run_status_next          = vras_pkg::ST_OK;
                            end
                        end
                        else
                        begin
                            stable_count_next = 8'd0;
                            if (item_reg.move_refused)
                            begin
                                do_fail = 1'b1;
                            end
                            else
                            begin
                                result_next.forward_move = fwd_scaled;
                                result_next.right_move   = rgt_scaled;
                                result_next.move_valid   = 1'b1;
                                move_pending_next        = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        // A frame from another mode or target leaves the state alone.
                    end
                end
            end
        endcase

        // Failure overrides the step's other effects on status.
        if (do_fail)
        begin
            result_next.stop_chassis = busy;
            result_next.camera_reset = 1'b1;
            move_pending_next        = 1'b0;
            run_status_next          = vras_pkg::ST_FAIL;
        end

        result_next.status = run_status_next;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= in_action;
            item_reg   <= in_item;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    // Servo state, updated as each item moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_status_reg   <= vras_pkg::ST_IDLE;
            move_pending_reg <= 1'b0;
            stable_count_reg <= 8'd0;
            start_time_reg   <= 32'd0;
            last_seen_reg    <= 32'd0;
        end
        else if (take)
        begin
            run_status_reg   <= run_status_next;
            move_pending_reg <= move_pending_next;
            stable_count_reg <= stable_count_next;
            start_time_reg   <= start_time_next;
            last_seen_reg    <= last_seen_next;
        end
    end

endmodule

[rtl/visual_ring_alignment_servo.sv]
// Channel  | Direction | Payload
// s_*      | in        | tuser: action; tdata: now_ms .. det_dy, one event per item
// m_*      | out       | tdata: status .. camera_set_target, one result per item
// APB p*   | in/out    | eight configuration registers at byte address 4*index
//
// Each item passes from the input register into the result register, and m_tvalid
// rises when the result register takes it; one item per cycle while m_tready does not stall.
// The combinational state update over the two gain multipliers sets that rate.
// Reset is asynchronous and active low; it clears the servo to idle and loads
// the configuration defaults. A stalled m_tready holds the result, and s_tready
// drops only once the input register is also full.
module visual_ring_alignment_servo #(
    parameter int TIMEOUT_MS   = 8000,
    parameter int STALE_MS     = 300,
    parameter int FINE_LIMIT   = 100,
    parameter int COARSE_LIMIT = 500,
    parameter int RING_ID      = 1,
    parameter int RING_MODE    = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // now_ms, chassis_state, move_refused, ack_failed, det_valid, det_mode,
    // det_target, det_found, det_quality, det_dx, det_dy; zero padded
    input  logic [vras_pkg::IN_TDATA_W-1:0]   s_tdata,
    // action
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status, start_accepted, move_valid, forward_move, right_move,
    // stop_chassis, camera_reset, camera_set_target; zero padded
    output logic [vras_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vras_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    vras_pkg::cfg_t    cfg;
    vras_pkg::item_t   item;
    vras_pkg::result_t result;

    assign item    = vras_pkg::item_t'(s_tdata[vras_pkg::ITEM_W-1:0]);
    assign m_tdata = {1'b0, result};

    // Configuration registers.
    vras_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Servo datapath and control.
    vras_core #(
        .TIMEOUT_MS   (TIMEOUT_MS),
        .STALE_MS     (STALE_MS),
        .FINE_LIMIT   (FINE_LIMIT),
        .COARSE_LIMIT (COARSE_LIMIT),
        .RING_ID      (RING_ID),
        .RING_MODE    (RING_MODE)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser),
        .in_item    (item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result),
        .cfg        (cfg)
    );

endmodule

[rtl/vras_checker.sv]
`include "visual_ring_alignment_servo_assert.svh"

// Port-level checks of the alignment servo.
module vras_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [vras_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    vras_pkg::result_t res;

    assign res = vras_pkg::result_t'(m_tdata[vras_pkg::RESULT_W-1:0]);

    // A result held back by the sink keeps its value.
    `VRAS_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The input side stalls only behind a stalled, full result register.
    `VRAS_ASSERT_SAME(a_stall, clk, rst_n, !s_tready, m_tvalid && !m_tready)

    // A move is only issued while the alignment keeps running.
    `VRAS_ASSERT_SAME(a_move_run, clk, rst_n, m_tvalid && res.move_valid, res.status == vras_pkg::ST_RUN && !res.camera_reset)

    // Without a move both move fields read zero.
    `VRAS_ASSERT_SAME(a_move_zero, clk, rst_n, m_tvalid && !res.move_valid, res.forward_move == 16'd0 && res.right_move == 16'd0)

    // A camera target request only comes with an accepted ring start.
    `VRAS_ASSERT_SAME(a_set_start, clk, rst_n, m_tvalid && res.camera_set_target, res.start_accepted && res.status == vras_pkg::ST_RUN)

endmodule

bind visual_ring_alignment_servo vras_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
